@@ sv/fals_pkg.sv @@
package fals_pkg;

	// Result status codes
	localparam logic [1:0] STATUS_READ_HIT   = 2'd0;
	localparam logic [1:0] STATUS_READ_MISS  = 2'd1;
	localparam logic [1:0] STATUS_WR_STORED  = 2'd2;
	localparam logic [1:0] STATUS_WR_REJECT  = 2'd3;

	// Request opcodes
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Field widths
	localparam int TAG_W    = 64;
	localparam int LEN_W    = 24;
	localparam int STAMP_W  = 64;
	localparam int LINE_W   = 4;
	localparam int STATUS_W = 2;

	// Configuration register map
	localparam int          PADDR_W          = 3;
	localparam logic [2:0]  ADDR_MAX_OBJ     = 3'd0;
	localparam logic [23:0] MAX_OBJ_RESET    = 24'd102400;

	// Packed stream widths
	localparam int S_TDATA_W = 88;
	localparam int M_TDATA_W = 32;

endpackage

@@ sv/fully_assoc_lru_tag_store.sv @@
// A new request is accepted only in idle, after the previous result has been committed;
// the single read port of the line memories is swept one line per cycle, and one tag
// compare and one stamp compare serve every line.
// Reset (arst_n low, asynchronous): all lines invalid, access clock zero,
// max_object_bytes = 102400, no result pending. No clearing pass is needed.
module fully_assoc_lru_tag_store
	import fals_pkg::*;
#(
	parameter int NUM_LINES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // [63:0] key_tag, [87:64] object_length
	input  logic                  s_tuser,  // [0] opcode
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // [3:0] line_index, [27:4] stored_length,
	                                        // [28] evicted, [31:29] zero
	output logic [STATUS_W-1:0]   m_tuser,  // [1:0] status
	// Configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int IW = $clog2(NUM_LINES);
	localparam int CW = $clog2(NUM_LINES + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(NUM_LINES);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]           state_q;
	logic [CW-1:0]        issue_cnt_q;
	logic                 rd_vld_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [TAG_W-1:0]     tag_rd_s1;
	logic [LEN_W-1:0]     len_rd_s1;
	logic [STAMP_W-1:0]   stamp_rd_s1;

	logic                 op_q;
	logic [TAG_W-1:0]     key_q;
	logic [LEN_W-1:0]     obj_len_q;

	logic                 hit_q;
	logic [IW-1:0]        hit_idx_q;
	logic [LEN_W-1:0]     hit_len_q;
	logic                 inv_q;
	logic [IW-1:0]        inv_idx_q;
	logic                 best_vld_q;
	logic [IW-1:0]        best_idx_q;
	logic [STAMP_W-1:0]   best_stamp_q;

	logic [NUM_LINES-1:0] line_valid_q;
	logic [STAMP_W-1:0]   access_clock_q;
	logic [LEN_W-1:0]     max_obj_q;

	logic [TAG_W-1:0]     tag_mem   [NUM_LINES];
	logic [LEN_W-1:0]     len_mem   [NUM_LINES];
	logic [STAMP_W-1:0]   stamp_mem [NUM_LINES];

	logic                 m_tvalid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [LINE_W-1:0]    line_index_q;
	logic [LEN_W-1:0]     stored_len_q;
	logic                 evicted_q;

	logic                 in_accept;
	logic                 commit;
	logic                 reject;
	logic [IW-1:0]        victim_idx;
	logic [IW-1:0]        rd_addr;
	logic                 stamp_we;
	logic [IW-1:0]        stamp_waddr;
	logic                 fill_we;
	logic [IW+LINE_W-1:0] hit_idx_ext;
	logic [IW+LINE_W-1:0] victim_ext;
	logic                 cfg_wr;

	// Handshake and commit decode
	assign s_tready    = (state_q == ST_IDLE);
	assign in_accept   = s_tvalid && s_tready;
	assign commit      = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);
	assign reject      = (obj_len_q > max_obj_q);
	assign victim_idx  = inv_q ? inv_idx_q : best_idx_q;
	assign rd_addr     = issue_cnt_q[IW-1:0];
	assign fill_we     = commit && (op_q == OP_WRITE) && !reject;
	assign stamp_we    = fill_we || (commit && (op_q == OP_READ) && hit_q);
	assign stamp_waddr = (op_q == OP_WRITE) ? victim_idx : hit_idx_q;
	assign hit_idx_ext = {{LINE_W{1'b0}}, hit_idx_q};
	assign victim_ext  = {{LINE_W{1'b0}}, victim_idx};

	// Sequencer: sweep every line, then commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_accept) begin
						state_q     <= ST_SCAN;
						issue_cnt_q <= '0;
					end
				end
				ST_SCAN: begin
					if (issue_cnt_q != LAST_CNT) begin
						rd_vld_s1   <= 1'b1;
						issue_cnt_q <= issue_cnt_q + 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					rd_vld_s1 <= 1'b0;
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q   <= ST_IDLE;
					rd_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q      <= s_tuser;
			key_q     <= s_tdata[TAG_W-1:0];
			obj_len_q <= s_tdata[TAG_W+LEN_W-1:TAG_W];
		end
	end

	// Line memories: one read port swept during the scan, one write port at commit
	always_ff @(posedge clk) begin
		rd_idx_s1   <= rd_addr;
		tag_rd_s1   <= tag_mem[rd_addr];
		len_rd_s1   <= len_mem[rd_addr];
		stamp_rd_s1 <= stamp_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (fill_we) begin
			tag_mem[victim_idx] <= key_q;
			len_mem[victim_idx] <= obj_len_q;
		end
	end

	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem[stamp_waddr] <= access_clock_q;
		end
	end

	// Compare stage: first hit, first invalid line, oldest valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			inv_q      <= 1'b0;
			best_vld_q <= 1'b0;
		end else if (in_accept) begin
			hit_q      <= 1'b0;
			inv_q      <= 1'b0;
			best_vld_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (line_valid_q[rd_idx_s1]) begin
				if (!hit_q && (tag_rd_s1 == key_q)) begin
					hit_q <= 1'b1;
				end
				if (!best_vld_q || (stamp_rd_s1 < best_stamp_q)) begin
					best_vld_q <= 1'b1;
				end
			end else if (!inv_q) begin
				inv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (line_valid_q[rd_idx_s1]) begin
				if (!hit_q && (tag_rd_s1 == key_q)) begin
					hit_idx_q <= rd_idx_s1;
					hit_len_q <= len_rd_s1;
				end
				if (!best_vld_q || (stamp_rd_s1 < best_stamp_q)) begin
					best_idx_q   <= rd_idx_s1;
					best_stamp_q <= stamp_rd_s1;
				end
			end else if (!inv_q) begin
				inv_idx_q <= rd_idx_s1;
			end
		end
	end

	// Valid bits and access clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_valid_q   <= '0;
			access_clock_q <= '0;
		end else begin
			if (fill_we) begin
				line_valid_q[victim_idx] <= 1'b1;
			end
			if (stamp_we) begin
				access_clock_q <= access_clock_q + 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= STATUS_READ_MISS;
			line_index_q <= '0;
			stored_len_q <= '0;
			evicted_q    <= 1'b0;
			if (op_q == OP_READ) begin
				if (hit_q) begin
					status_q     <= STATUS_READ_HIT;
					line_index_q <= hit_idx_ext[LINE_W-1:0];
					stored_len_q <= hit_len_q;
				end
			end else if (reject) begin
				status_q <= STATUS_WR_REJECT;
			end else begin
				status_q     <= STATUS_WR_STORED;
				line_index_q <= victim_ext[LINE_W-1:0];
				evicted_q    <= !inv_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, evicted_q, stored_len_q, line_index_q};

	// Configuration register
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_obj_q <= MAX_OBJ_RESET;
		end else if (cfg_wr && (paddr == ADDR_MAX_OBJ)) begin
			max_obj_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_MAX_OBJ) ? {8'h00, max_obj_q} : 32'h0;

endmodule

@@ tb/sv/tb_fully_assoc_lru_tag_store.sv @@
module tb_fully_assoc_lru_tag_store;
	timeunit 1ns;
	timeprecision 1ps;
	import fals_pkg::*;

	localparam int LINES    = 16;
	localparam int TAG_POOL = 24;
	localparam logic [PADDR_W-1:0] ADDR_UNUSED = 3'd4;

	typedef struct packed {
		logic             op;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [LINE_W-1:0]   line;
		logic [LEN_W-1:0]    len;
		logic                evicted;
	} result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // [63:0] key_tag, [87:64] object_length
	logic                 s_tuser  = 1'b0; // [0] opcode
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;  // [3:0] line_index, [27:4] stored_length, [28] evicted
	logic [STATUS_W-1:0]  m_tuser;  // [1:0] status
	logic                 psel     = 1'b0;
	logic                 penable  = 1'b0;
	logic                 pwrite   = 1'b0;
	logic [PADDR_W-1:0]   paddr    = '0;
	logic [31:0]          pwdata   = '0;
	logic [31:0]          prdata;
	logic                 pready;

	// Tag store mirror
	logic                 line_valid [LINES];
	logic [TAG_W-1:0]     line_tag   [LINES];
	logic [LEN_W-1:0]     line_len   [LINES];
	logic [STAMP_W-1:0]   line_stamp [LINES];
	logic [STAMP_W-1:0]   access_clock = '0;
	logic [LEN_W-1:0]     max_bytes    = MAX_OBJ_RESET;

	request_t             request_queue [$];
	result_t              expected_results [$];
	logic [TAG_W-1:0]     tag_pool [TAG_POOL];
	request_t             drv_item;
	request_t             taken_item;
	result_t              want;
	logic                 s_fire = 1'b0;
	int                   stall_pct = 18;
	int                   failures = 0;

	fully_assoc_lru_tag_store #(.NUM_LINES(LINES)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	initial begin
		for (int i = 0; i < LINES; i++) begin
			line_valid[i] = 1'b0;
			line_tag[i]   = '0;
			line_len[i]   = '0;
			line_stamp[i] = '0;
		end
	end

	// Look up or insert one request and return the result it must produce
	function automatic result_t apply_request(request_t r);
		result_t res;
		int      victim;
		res    = '0;
		victim = -1;
		if (r.op == OP_READ) begin
			for (int i = 0; i < LINES; i++) begin
				if (line_valid[i] && line_tag[i] == r.tag) begin
					line_stamp[i] = access_clock;
					access_clock  = access_clock + 1;
					res.status    = STATUS_READ_HIT;
					res.line      = i[LINE_W-1:0];
					res.len       = line_len[i];
					return res;
				end
			end
			res.status = STATUS_READ_MISS;
			return res;
		end
		if (r.len > max_bytes) begin
			res.status = STATUS_WR_REJECT;
			return res;
		end
		// Lowest invalid line first, else the oldest stamp
		for (int i = 0; i < LINES; i++)
			if (victim < 0 && !line_valid[i])
				victim = i;
		if (victim < 0) begin
			victim = 0;
			for (int i = 1; i < LINES; i++)
				if (line_stamp[i] < line_stamp[victim])
					victim = i;
		end
		res.status         = STATUS_WR_STORED;
		res.line           = victim[LINE_W-1:0];
		res.evicted        = line_valid[victim];
		line_valid[victim] = 1'b1;
		line_tag[victim]   = r.tag;
		line_len[victim]   = r.len;
		line_stamp[victim] = access_clock;
		access_clock       = access_clock + 1;
		return res;
	endfunction

	function automatic request_t make_request();
		request_t r;
		int       pick;
		r.op = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 88)
			r.tag = tag_pool[$urandom_range(0, TAG_POOL - 1)];
		else
			r.tag = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 70)
			r.len = LEN_W'($urandom_range(0, max_bytes));
		else if (pick < 80)
			r.len = max_bytes;
		else if (pick < 88)
			r.len = max_bytes + 1'b1;
		else
			r.len = LEN_W'($urandom);
		return r;
	endfunction

	task automatic queue_request(input logic op, input logic [TAG_W-1:0] tag,
			input logic [LEN_W-1:0] len);
		request_t r;
		r.op  = op;
		r.tag = tag;
		r.len = len;
		request_queue.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
			failures++;
		end
	endtask

	// Hold until every item has been sent and answered; look once the driver has settled
	task automatic drain();
		do begin
			@(negedge clk);
			#1;
		end while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	// Write one register, then read the limit register back
	task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (addr == ADDR_MAX_OBJ)
			max_bytes = value[LEN_W-1:0];
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b0;
		paddr   = ADDR_MAX_OBJ;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		check_field("max_object_bytes", {8'd0, max_bytes}, {8'd0, prdata[LEN_W-1:0]});
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Request driver: present the next item once the previous one is taken
	always @(negedge clk) begin
		if (!s_tvalid || s_fire) begin
			if (request_queue.size() > 0 && $urandom_range(0, 99) >= stall_pct) begin
				drv_item = request_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {drv_item.len, drv_item.tag};
				s_tuser  <= drv_item.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Predict the result of every accepted item
	always @(posedge clk) begin
		s_fire <= s_tvalid && s_tready;
		if (s_tvalid && s_tready) begin
			taken_item.op  = s_tuser;
			taken_item.tag = s_tdata[TAG_W-1:0];
			taken_item.len = s_tdata[TAG_W+LEN_W-1:TAG_W];
			expected_results.push_back(apply_request(taken_item));
		end
	end

	// Result monitor
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= stall_pct);

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result item: status %0d, tdata 0x%0h", m_tuser, m_tdata);
				failures++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", {30'd0, want.status}, {30'd0, m_tuser});
				check_field("line_index", {28'd0, want.line}, {28'd0, m_tdata[3:0]});
				check_field("stored_length", {8'd0, want.len}, {8'd0, m_tdata[27:4]});
				check_field("evicted", {31'd0, want.evicted}, {31'd0, m_tdata[28]});
			end
		end
	end

	initial begin
		logic [TAG_W-1:0] spare_tag;
		logic [31:0]      limit;
		int               count;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty store, length extremes, hits, duplicates, fill and evict
		spare_tag = {$urandom, $urandom};
		queue_request(OP_READ, '0, '0);
		queue_request(OP_WRITE, '0, '0);
		queue_request(OP_WRITE, '1, MAX_OBJ_RESET);
		queue_request(OP_WRITE, spare_tag, MAX_OBJ_RESET + 1'b1);
		queue_request(OP_WRITE, spare_tag, '1);
		queue_request(OP_READ, '1, '1);
		queue_request(OP_READ, '0, '0);
		queue_request(OP_WRITE, '0, 24'd5);
		queue_request(OP_READ, '0, '0);
		for (int i = 0; i < LINES - 3; i++)
			queue_request(OP_WRITE, {$urandom, $urandom},
				LEN_W'($urandom_range(0, MAX_OBJ_RESET)));
		queue_request(OP_WRITE, spare_tag, 24'd77);
		queue_request(OP_READ, '1, '0);
		drain();

		// Zero limit: only empty objects fit
		cfg_write(ADDR_MAX_OBJ, 32'd0);
		queue_request(OP_WRITE, spare_tag, '0);
		queue_request(OP_WRITE, spare_tag, 24'd1);
		drain();

		// Full limit, upper bus bits dropped
		cfg_write(ADDR_MAX_OBJ, 32'hFFFF_FFFF);
		queue_request(OP_WRITE, ~spare_tag, '1);
		queue_request(OP_READ, ~spare_tag, '0);
		drain();

		// Write to an unmapped address leaves the limit alone
		cfg_write(ADDR_UNUSED, 32'd7);
		queue_request(OP_WRITE, spare_tag ^ 64'h5A, '1);
		drain();

		// Random phases over several limits; the second one never idles
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: limit = {8'd0, MAX_OBJ_RESET};
				1: limit = 32'd1000;
				2: limit = 32'd0;
				3: limit = 32'hFFFF_FFFF;
				default: limit = $urandom;
			endcase
			count     = (p == 2) ? 100 : 400;
			stall_pct = (p == 1) ? 0 : 18;
			cfg_write(ADDR_MAX_OBJ, limit);
			for (int k = 0; k < TAG_POOL; k++)
				tag_pool[k] = {$urandom, $urandom};
			for (int n = 0; n < count; n++)
				request_queue.push_back(make_request());
			drain();
		end

		repeat (40) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
